// ----- design/stt_pkg.sv -----
// Shared types, token codes, character classes and keyword table for the tokenizer.
`default_nettype none

package stt_pkg;

    localparam int POSITION_BITS_DEF     = 24;
    localparam int KEYWORD_MAX_CHARS_DEF = 7;
    localparam int FIELD_BITS            = 24;
    localparam int KW_COUNT              = 27;
    localparam int REC_SLOTS             = 3;

    typedef logic [5:0] kind_t;

    localparam kind_t K_SLASH       = 6'd13;
    localparam kind_t K_BANG        = 6'd14;
    localparam kind_t K_BANG_EQ     = 6'd15;
    localparam kind_t K_EQ          = 6'd16;
    localparam kind_t K_EQ_EQ       = 6'd17;
    localparam kind_t K_GT          = 6'd18;
    localparam kind_t K_GE          = 6'd19;
    localparam kind_t K_SHR         = 6'd20;
    localparam kind_t K_LT          = 6'd21;
    localparam kind_t K_LE          = 6'd22;
    localparam kind_t K_SHL         = 6'd23;
    localparam kind_t K_AND         = 6'd24;
    localparam kind_t K_AND_AND     = 6'd25;
    localparam kind_t K_OR          = 6'd26;
    localparam kind_t K_OR_OR       = 6'd27;
    localparam kind_t K_IDENT       = 6'd28;
    localparam kind_t K_STRING      = 6'd29;
    localparam kind_t K_NUMBER      = 6'd30;
    localparam kind_t K_ERR_UNKNOWN = 6'd47;
    localparam kind_t K_ERR_UNTERM  = 6'd48;
    localparam kind_t K_END         = 6'd49;

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_DOT, M_XP, M_FRAC, M_HEX, M_IDENT, M_STR, M_CMT,
        M_SLASH, M_BANG, M_EQ, M_GT, M_LT, M_AMP, M_PIPE
    } mode_t;

    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] offset;
        logic [FIELD_BITS-1:0] span;
        logic [FIELD_BITS-1:0] line;
        logic                  last;
    } rec_t;

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("let"), 64'("const"), 64'("pointer"), 64'("true"), 64'("false"),
        64'("null"), 64'("if"), 64'("elseif"), 64'("else"), 64'("while"),
        64'("for"), 64'("fn"), 64'("return"), 64'("load"),
        64'("int8"), 64'("int16"), 64'("int32"), 64'("int64"),
        64'("uint8"), 64'("uint16"), 64'("uint32"), 64'("uint64"),
        64'("float"), 64'("string"), 64'("void"), 64'("bool"), 64'("print")
    };

    localparam int KW_LEN [KW_COUNT] = '{
        3, 5, 7, 4, 5, 4, 2, 6, 4, 5, 3, 2, 6, 4,
        4, 5, 5, 5, 5, 6, 6, 6, 5, 6, 4, 4, 5
    };

    localparam kind_t KW_KIND [KW_COUNT] = '{
        6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
        6'd41, 6'd42, 6'd43, 6'd44,
        6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45,
        6'd45, 6'd45, 6'd45, 6'd45, 6'd46
    };

    // first character in the lowest byte
    function automatic logic [63:0] pack_le(input logic [63:0] lit, input int len);
        logic [63:0] r;
        r = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (j < len)
            begin
                r[8*j +: 8] = lit[8*(len-1-j) +: 8];
            end
        end
        return r;
    endfunction

    function automatic kind_t kw_kind(input logic [63:0] wtext, input logic [3:0] n);
        kind_t k;
        logic  hit;
        k   = K_IDENT;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (!hit && n == 4'(KW_LEN[i]) && wtext == pack_le(KW_TEXT[i], KW_LEN[i]))
            begin
                hit = 1'b1;
                k   = KW_KIND[i];
            end
        end
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    // bit 6 set when the byte is a one-character token
    function automatic logic [6:0] single_kind(input logic [7:0] c);
        logic [6:0] r;
        case (c)
            "(":     r = {1'b1, 6'd0};
            ")":     r = {1'b1, 6'd1};
            "{":     r = {1'b1, 6'd2};
            "}":     r = {1'b1, 6'd3};
            ",":     r = {1'b1, 6'd4};
            ":":     r = {1'b1, 6'd5};
            ";":     r = {1'b1, 6'd6};
            "-":     r = {1'b1, 6'd7};
            "+":     r = {1'b1, 6'd8};
            "*":     r = {1'b1, 6'd9};
            "%":     r = {1'b1, 6'd10};
            "^":     r = {1'b1, 6'd11};
            "~":     r = {1'b1, 6'd12};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/stt_scan.sv -----
// Scanner state registers and the per-byte token logic producing up to three records.
`default_nettype none

module stt_scan
    import stt_pkg::*;
#(
    parameter int POSITION_BITS     = POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = KEYWORD_MAX_CHARS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [7:0]                 item_byte,
    input  wire logic                       item_end,
    output rec_t      [REC_SLOTS-1:0]       recs,
    output logic      [1:0]                 rec_cnt
);

    localparam int PB = POSITION_BITS;
    localparam int KM = KEYWORD_MAX_CHARS;
    localparam int WB = 8 * KEYWORD_MAX_CHARS;
    localparam logic [PB-1:0] POS_MAX = '1;

    mode_t          mode_reg, mode_next;
    logic [PB-1:0]  pos_reg,  pos_next;
    logic [PB-1:0]  beg_reg,  beg_next;
    logic [PB-1:0]  line_reg, line_next;
    logic [WB-1:0]  wbuf_reg, wbuf_next;
    logic [3:0]     wch_reg,  wch_next;

    mode_t          mode;
    logic [PB-1:0]  pos, beg, line, held;
    logic [WB-1:0]  wbuf;
    logic [3:0]     wch;
    logic           done;
    logic [1:0]     n, ecnt;
    kind_t          ek [REC_SLOTS];
    logic [PB-1:0]  eo [REC_SLOTS];
    logic [PB-1:0]  es [REC_SLOTS];
    logic [7:0]     c;
    logic [6:0]     sk;

    function automatic logic [FIELD_BITS-1:0] clampf(input logic [PB-1:0] v);
        return (33'(v) > 33'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}} : FIELD_BITS'(v);
    endfunction

    function automatic logic [PB-1:0] span_of(input logic [PB-1:0] p, input logic [PB-1:0] b);
        return (p >= b) ? p - b : '0;
    endfunction

    function automatic kind_t word_kind(input logic [WB-1:0] w, input logic [3:0] k);
        kind_t r;
        if (k == 4'd0 || k > 4'(KM))
        begin
            r = K_IDENT;
        end
        else
        begin
            r = kw_kind(64'(w), k);
        end
        return r;
    endfunction

    always_comb
    begin
        mode = mode_reg;
        pos  = pos_reg;
        beg  = beg_reg;
        line = line_reg;
        wbuf = wbuf_reg;
        wch  = wch_reg;
        done = 1'b0;
        n    = '0;
        ecnt = '0;
        held = '0;
        c    = item_byte;
        sk   = single_kind(item_byte);
        recs = '0;
        for (int e = 0; e < REC_SLOTS; e++)
        begin
            ek[e] = '0;
            eo[e] = '0;
            es[e] = '0;
        end

        if (item_end)
        begin
            held = (pos != '0) ? pos - 1'b1 : '0;
            case (mode)
                M_INT, M_FRAC, M_HEX:
                begin
                    ek[0] = K_NUMBER; eo[0] = beg; es[0] = span_of(pos, beg); ecnt = 2'd1;
                end
                M_DOT:
                begin
                    ek[0] = K_NUMBER; eo[0] = beg; es[0] = span_of(held, beg);
                    ek[1] = K_ERR_UNKNOWN; eo[1] = held; es[1] = PB'(1); ecnt = 2'd2;
                end
                M_XP:
                begin
                    ek[0] = K_NUMBER; eo[0] = beg; es[0] = span_of(held, beg);
                    ek[1] = word_kind(wbuf, 4'd1); eo[1] = held; es[1] = span_of(pos, held);
                    ecnt = 2'd2;
                end
                M_IDENT:
                begin
                    ek[0] = word_kind(wbuf, wch); eo[0] = beg; es[0] = span_of(pos, beg);
                    ecnt = 2'd1;
                end
                M_STR:   begin ek[0] = K_ERR_UNTERM; ecnt = 2'd1; end
                M_SLASH: begin ek[0] = K_SLASH; ecnt = 2'd1; end
                M_BANG:  begin ek[0] = K_BANG;  ecnt = 2'd1; end
                M_EQ:    begin ek[0] = K_EQ;    ecnt = 2'd1; end
                M_GT:    begin ek[0] = K_GT;    ecnt = 2'd1; end
                M_LT:    begin ek[0] = K_LT;    ecnt = 2'd1; end
                M_AMP:   begin ek[0] = K_AND;   ecnt = 2'd1; end
                M_PIPE:  begin ek[0] = K_OR;    ecnt = 2'd1; end
                default: ecnt = 2'd0;
            endcase
            if (ecnt == 2'd1 && mode != M_INT && mode != M_FRAC && mode != M_HEX
                && mode != M_IDENT)
            begin
                eo[0] = beg;
                es[0] = span_of(pos, beg);
            end
            ek[ecnt] = K_END;
            eo[ecnt] = pos;
            es[ecnt] = '0;
            for (int e = 0; e < REC_SLOTS; e++)
            begin
                if (e <= int'(ecnt))
                begin
                    recs[e] = '{kind: ek[e], offset: clampf(eo[e]), span: clampf(es[e]),
                                line: clampf(line), last: (e == int'(ecnt))};
                end
            end
            n = ecnt + 2'd1;
        end
        else
        begin
            for (int it = 0; it < 4; it++)
            begin
                if (!done)
                begin
                    done = 1'b1;
                    ecnt = '0;
                    held = (pos != '0) ? pos - 1'b1 : '0;
                    case (mode)
                        M_IDLE:
                        begin
                            beg = pos;
                            if (pos < POS_MAX) pos = pos + 1'b1;
                            if (is_digit(c))
                            begin
                                mode = M_INT;
                            end
                            else if (is_alpha(c))
                            begin
                                wbuf = WB'(c);
                                wch  = 4'd1;
                                mode = M_IDENT;
                            end
                            else if (sk[6])
                            begin
                                ek[0] = sk[5:0]; eo[0] = beg; es[0] = span_of(pos, beg);
                                ecnt = 2'd1;
                            end
                            else
                            begin
                                case (c)
                                    8'h22: mode = M_STR;
                                    "/":   mode = M_SLASH;
                                    "!":   mode = M_BANG;
                                    "=":   mode = M_EQ;
                                    ">":   mode = M_GT;
                                    "<":   mode = M_LT;
                                    "&":   mode = M_AMP;
                                    "|":   mode = M_PIPE;
                                    8'h20, 8'h0d, 8'h09: mode = M_IDLE;
                                    8'h0a: if (line < POS_MAX) line = line + 1'b1;
                                    default:
                                    begin
                                        ek[0] = K_ERR_UNKNOWN; eo[0] = beg;
                                        es[0] = span_of(pos, beg); ecnt = 2'd1;
                                    end
                                endcase
                            end
                        end
                        M_INT:
                        begin
                            if (is_digit(c))
                            begin
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else if (c == ".")
                            begin
                                mode = M_DOT;
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else if (c == "x" || c == "X")
                            begin
                                wbuf = WB'(c);
                                mode = M_XP;
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else
                            begin
                                ek[0] = K_NUMBER; eo[0] = beg; es[0] = span_of(pos, beg);
                                ecnt = 2'd1; mode = M_IDLE; done = 1'b0;
                            end
                        end
                        M_DOT:
                        begin
                            if (is_digit(c))
                            begin
                                mode = M_FRAC;
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else
                            begin
                                ek[0] = K_NUMBER; eo[0] = beg; es[0] = span_of(held, beg);
                                ek[1] = K_ERR_UNKNOWN; eo[1] = held; es[1] = PB'(1);
                                ecnt = 2'd2; mode = M_IDLE; done = 1'b0;
                            end
                        end
                        M_XP:
                        begin
                            if (is_alnum(c))
                            begin
                                mode = M_HEX;
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else
                            begin
                                ek[0] = K_NUMBER; eo[0] = beg; es[0] = span_of(held, beg);
                                ecnt = 2'd1;
                                beg  = held;
                                wch  = 4'd1;
                                mode = M_IDENT;
                                done = 1'b0;
                            end
                        end
                        M_FRAC, M_HEX:
                        begin
                            if ((mode == M_FRAC) ? is_digit(c) : is_alnum(c))
                            begin
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else
                            begin
                                ek[0] = K_NUMBER; eo[0] = beg; es[0] = span_of(pos, beg);
                                ecnt = 2'd1; mode = M_IDLE; done = 1'b0;
                            end
                        end
                        M_IDENT:
                        begin
                            if (is_alnum(c) || c == "_")
                            begin
                                if (wch < 4'(KM))
                                begin
                                    wbuf = wbuf | (WB'(c) << (8 * int'(wch)));
                                    wch  = wch + 4'd1;
                                end
                                else
                                begin
                                    wch = 4'(KM + 1);
                                end
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else
                            begin
                                ek[0] = word_kind(wbuf, wch); eo[0] = beg;
                                es[0] = span_of(pos, beg);
                                ecnt = 2'd1; mode = M_IDLE; done = 1'b0;
                            end
                        end
                        M_STR:
                        begin
                            if (pos < POS_MAX) pos = pos + 1'b1;
                            if (c == 8'h22)
                            begin
                                ek[0] = K_STRING; eo[0] = beg; es[0] = span_of(pos, beg);
                                ecnt = 2'd1; mode = M_IDLE;
                            end
                            else if (c == 8'h0a && line < POS_MAX)
                            begin
                                line = line + 1'b1;
                            end
                        end
                        M_CMT:
                        begin
                            if (c == 8'h0a)
                            begin
                                mode = M_IDLE; done = 1'b0;
                            end
                            else if (pos < POS_MAX)
                            begin
                                pos = pos + 1'b1;
                            end
                        end
                        M_SLASH:
                        begin
                            if (c == "/")
                            begin
                                mode = M_CMT;
                                if (pos < POS_MAX) pos = pos + 1'b1;
                            end
                            else
                            begin
                                ek[0] = K_SLASH; eo[0] = beg; es[0] = span_of(pos, beg);
                                ecnt = 2'd1; mode = M_IDLE; done = 1'b0;
                            end
                        end
                        M_BANG, M_EQ, M_AMP, M_PIPE, M_GT, M_LT:
                        begin
                            ecnt = 2'd1;
                            if ((mode == M_GT && c == ">") || (mode == M_LT && c == "<"))
                            begin
                                if (pos < POS_MAX) pos = pos + 1'b1;
                                ek[0] = (mode == M_GT) ? K_SHR : K_SHL;
                            end
                            else if ((c == "=" && (mode == M_BANG || mode == M_EQ
                                     || mode == M_GT || mode == M_LT))
                                     || (c == "&" && mode == M_AMP)
                                     || (c == "|" && mode == M_PIPE))
                            begin
                                if (pos < POS_MAX) pos = pos + 1'b1;
                                case (mode)
                                    M_BANG:  ek[0] = K_BANG_EQ;
                                    M_EQ:    ek[0] = K_EQ_EQ;
                                    M_GT:    ek[0] = K_GE;
                                    M_LT:    ek[0] = K_LE;
                                    M_AMP:   ek[0] = K_AND_AND;
                                    default: ek[0] = K_OR_OR;
                                endcase
                            end
                            else
                            begin
                                done = 1'b0;
                                case (mode)
                                    M_BANG:  ek[0] = K_BANG;
                                    M_EQ:    ek[0] = K_EQ;
                                    M_GT:    ek[0] = K_GT;
                                    M_LT:    ek[0] = K_LT;
                                    M_AMP:   ek[0] = K_AND;
                                    default: ek[0] = K_OR;
                                endcase
                            end
                            eo[0] = beg;
                            es[0] = span_of(pos, beg);
                            mode  = M_IDLE;
                        end
                        default:
                        begin
                            mode = M_IDLE; done = 1'b0;
                        end
                    endcase
                    for (int e = 0; e < 2; e++)
                    begin
                        if (e < int'(ecnt) && n < 2'd3)
                        begin
                            recs[n] = '{kind: ek[e], offset: clampf(eo[e]),
                                        span: clampf(es[e]), line: clampf(line),
                                        last: 1'b0};
                            n = n + 2'd1;
                        end
                    end
                end
            end
            if (n != 2'd0)
            begin
                recs[n - 2'd1].last = 1'b1;
            end
        end
        rec_cnt = n;

        if (item_end)
        begin
            mode_next = M_IDLE;
            pos_next  = '0;
            beg_next  = '0;
            line_next = PB'(1);
            wbuf_next = '0;
            wch_next  = '0;
        end
        else
        begin
            mode_next = mode;
            pos_next  = pos;
            beg_next  = beg;
            line_next = line;
            wbuf_next = wbuf;
            wch_next  = wch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            beg_reg  <= '0;
            line_reg <= PB'(1);
            wbuf_reg <= '0;
            wch_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            beg_reg  <= beg_next;
            line_reg <= line_next;
            wbuf_reg <= wbuf_next;
            wch_reg  <= wch_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/stt_outq.sv -----
// Result register holding one item's records and handing them out one per request.
`default_nettype none

module stt_outq
    import stt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire rec_t [REC_SLOTS-1:0]    recs,
    input  wire logic [1:0]              rec_cnt,
    output logic                         free,
    output logic                         tok_valid,
    input  wire logic                    tok_stall,
    output rec_t                         rec_out
);

    rec_t [REC_SLOTS-1:0] recs_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           idx_reg;
    logic                 pop;
    logic                 last_pop;

    assign tok_valid = (cnt_reg != 2'd0);
    assign pop       = tok_valid && !tok_stall;
    assign last_pop  = pop && (idx_reg == cnt_reg - 2'd1);
    assign free      = !tok_valid || last_pop;
    assign rec_out   = recs_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= rec_cnt;
            idx_reg <= '0;
        end
        else if (last_pop)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            recs_reg <= recs;
        end
    end

endmodule

`default_nettype wire

// ----- design/source_text_tokenizer.sv -----
// Top level of the streaming source tokenizer: input register, scanner and result register.
//
// Takes one source byte (or end marker) per request and returns token records
// (kind, offset, length, line), which are registered in the result register. An
// item is taken every cycle while each item yields at most one record and the
// receiver does not stall; an item that closes several tokens (up to three) holds
// the result register until all its records have left, since records leave one per
// output request. The end marker flushes any held token, emits the end-of-source
// record and returns the scanner to its reset state.
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int POSITION_BITS     = POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = KEYWORD_MAX_CHARS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    output logic             src_stall,
    input  wire logic [7:0]  source_byte,
    input  wire logic        end_marker,
    output logic             tok_valid,
    input  wire logic        tok_stall,
    output logic [5:0]       token_kind,
    output logic [23:0]      token_offset,
    output logic [23:0]      token_span,
    output logic [23:0]      token_line,
    output logic             last_of_run
);

    logic                 item_valid_reg;
    logic [7:0]           byte_reg;
    logic                 end_reg;
    logic                 free;
    logic                 advance;
    logic                 accept;
    rec_t [REC_SLOTS-1:0] recs;
    logic [1:0]           rec_cnt;
    rec_t                 rec_out;

    assign advance   = item_valid_reg && free;
    assign src_stall = item_valid_reg && !free;
    assign accept    = src_valid && !src_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= source_byte;
            end_reg  <= end_marker;
        end
    end

    stt_scan #(
        .POSITION_BITS     (POSITION_BITS),
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_byte (byte_reg),
        .item_end  (end_reg),
        .recs      (recs),
        .rec_cnt   (rec_cnt)
    );

    stt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .recs      (recs),
        .rec_cnt   (rec_cnt),
        .free      (free),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .rec_out   (rec_out)
    );

    assign token_kind   = rec_out.kind;
    assign token_offset = rec_out.offset;
    assign token_span   = rec_out.span;
    assign token_line   = rec_out.line;
    assign last_of_run  = rec_out.last;

endmodule

`default_nettype wire

// ----- design/stt_checker.sv -----
// Port-level checks for the tokenizer, bound to the top level.
`default_nettype none

module stt_checker
    import stt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        src_valid,
    input wire logic        src_stall,
    input wire logic [7:0]  source_byte,
    input wire logic        end_marker,
    input wire logic        tok_valid,
    input wire logic        tok_stall,
    input wire logic [5:0]  token_kind,
    input wire logic [23:0] token_offset,
    input wire logic [23:0] token_span,
    input wire logic [23:0] token_line,
    input wire logic        last_of_run
);

    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(source_byte)
            && $stable(end_marker))
        else $error("stalled source request changed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(token_kind)
            && $stable(token_offset) && $stable(last_of_run))
        else $error("stalled token record changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> token_kind <= K_END)
        else $error("token kind out of range");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind == K_END |-> last_of_run && token_span == 24'd0)
        else $error("end record not last or has nonzero span");

    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> token_line != 24'd0)
        else $error("line count zero");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire

// ----- sim/source_text_tokenizer_tb.sv -----
// Testbench for source_text_tokenizer: self-checking stream test with a scanner model.
`default_nettype none

module source_text_tokenizer_tb;
    import stt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [23:0] POS_TOP = 24'hFFFFFF;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } request_t;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] offset;
        logic [23:0] span;
        logic [23:0] line;
        logic        last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic [7:0]  source_byte;
    logic        end_marker;
    logic        tok_valid;
    logic        tok_stall;
    logic [5:0]  token_kind;
    logic [23:0] token_offset;
    logic [23:0] token_span;
    logic [23:0] token_line;
    logic        last_of_run;

    request_t pending_reqs[$];
    token_t   expected_tokens[$];
    int       errors;
    int       cycles;
    bit       quiet_mode;
    int       hold_long;
    bit       drain_pause;
    int       src_gap;
    int       rx_gap;
    bit       src_taken;

    // scanner model state
    mode_t       sc_mode;
    logic [23:0] sc_pos;
    logic [23:0] sc_begin;
    logic [23:0] sc_line;
    logic [63:0] sc_word;
    logic [3:0]  sc_chars;
    token_t      run_toks[$];

    source_text_tokenizer uut (
        .clk(clk), .rst_n(rst_n), .src_valid(src_valid), .src_stall(src_stall),
        .source_byte(source_byte), .end_marker(end_marker), .tok_valid(tok_valid),
        .tok_stall(tok_stall), .token_kind(token_kind), .token_offset(token_offset),
        .token_span(token_span), .token_line(token_line), .last_of_run(last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [63:0] pack_word(string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic logic [5:0] word_token_kind();
        string words[27];
        logic [5:0] kinds[27];
        words = '{"let", "const", "pointer", "true", "false", "null", "if", "elseif",
                  "else", "while", "for", "fn", "return", "load", "int8", "int16",
                  "int32", "int64", "uint8", "uint16", "uint32", "uint64", "float",
                  "string", "void", "bool", "print"};
        kinds = '{6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
                  6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd45, 6'd45,
                  6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd46};
        if (sc_chars == 0 || sc_chars > 7)
            return K_IDENT;
        for (int i = 0; i < 27; i++)
            if (words[i].len() == sc_chars && pack_word(words[i]) == sc_word)
                return kinds[i];
        return K_IDENT;
    endfunction

    function automatic void put_token(logic [5:0] k, logic [23:0] off, logic [23:0] len);
        token_t t;
        if (run_toks.size() >= 3)
            return;
        t.kind = k;
        t.offset = off;
        t.span = len;
        t.line = sc_line;
        t.last = 1'b0;
        run_toks.push_back(t);
    endfunction

    function automatic void add_here(logic [5:0] k);
        put_token(k, sc_begin, sc_pos >= sc_begin ? sc_pos - sc_begin : 24'd0);
    endfunction

    function automatic void advance();
        if (sc_pos < POS_TOP)
            sc_pos++;
    endfunction

    function automatic void bump_line();
        if (sc_line < POS_TOP)
            sc_line++;
    endfunction

    function automatic void word_push(logic [7:0] c);
        if (sc_chars < 7)
        begin
            sc_word[8*sc_chars +: 8] = c;
            sc_chars++;
        end
        else
            sc_chars = 8;
    endfunction

    function automatic logic [23:0] held_at();
        return sc_pos > 0 ? sc_pos - 24'd1 : 24'd0;
    endfunction

    function automatic void number_before_held();
        logic [23:0] p;
        p = held_at();
        put_token(K_NUMBER, sc_begin, p >= sc_begin ? p - sc_begin : 24'd0);
    endfunction

    function automatic void close_dot();
        logic [23:0] p;
        p = held_at();
        number_before_held();
        put_token(K_ERR_UNKNOWN, p, 24'd1);
        sc_mode = M_IDLE;
    endfunction

    function automatic void close_x();
        number_before_held();
        sc_begin = held_at();
        sc_chars = 1;
        sc_mode = M_IDENT;
    endfunction

    function automatic int single_code(logic [7:0] c);
        case (c)
            "(": return 0;
            ")": return 1;
            "{": return 2;
            "}": return 3;
            ",": return 4;
            ":": return 5;
            ";": return 6;
            "-": return 7;
            "+": return 8;
            "*": return 9;
            "%": return 10;
            "^": return 11;
            "~": return 12;
            default: return -1;
        endcase
    endfunction

    function automatic void begin_token(logic [7:0] c);
        int k;
        sc_begin = sc_pos;
        advance();
        if (dig(c))
        begin
            sc_mode = M_INT;
            return;
        end
        if (alp(c))
        begin
            sc_word = '0;
            sc_chars = 0;
            word_push(c);
            sc_mode = M_IDENT;
            return;
        end
        k = single_code(c);
        if (k >= 0)
        begin
            add_here(6'(k));
            return;
        end
        case (c)
            "\"": sc_mode = M_STR;
            "/": sc_mode = M_SLASH;
            "!": sc_mode = M_BANG;
            "=": sc_mode = M_EQ;
            ">": sc_mode = M_GT;
            "<": sc_mode = M_LT;
            "&": sc_mode = M_AMP;
            "|": sc_mode = M_PIPE;
            " ", 8'h0D, 8'h09: ;
            8'h0A: bump_line();
            default: add_here(K_ERR_UNKNOWN);
        endcase
    endfunction

    function automatic bit pair(logic [7:0] c, logic [7:0] second, logic [5:0] k2,
                                logic [5:0] k1);
        sc_mode = M_IDLE;
        if (c == second)
        begin
            advance();
            add_here(k2);
            return 1;
        end
        add_here(k1);
        return 0;
    endfunction

    // true when the byte was taken
    function automatic bit scan_byte(logic [7:0] c);
        bit an;
        an = dig(c) || alp(c);
        case (sc_mode)
            M_IDLE:
            begin
                begin_token(c);
                return 1;
            end
            M_INT:
            begin
                if (dig(c))
                begin
                    advance();
                    return 1;
                end
                if (c == ".")
                begin
                    sc_mode = M_DOT;
                    advance();
                    return 1;
                end
                if (c == "x" || c == "X")
                begin
                    sc_word = 64'(c);
                    sc_mode = M_XP;
                    advance();
                    return 1;
                end
                add_here(K_NUMBER);
                sc_mode = M_IDLE;
                return 0;
            end
            M_DOT:
            begin
                if (dig(c))
                begin
                    sc_mode = M_FRAC;
                    advance();
                    return 1;
                end
                close_dot();
                return 0;
            end
            M_XP:
            begin
                if (an)
                begin
                    sc_mode = M_HEX;
                    advance();
                    return 1;
                end
                close_x();
                return 0;
            end
            M_FRAC, M_HEX:
            begin
                if (sc_mode == M_FRAC ? dig(c) : an)
                begin
                    advance();
                    return 1;
                end
                add_here(K_NUMBER);
                sc_mode = M_IDLE;
                return 0;
            end
            M_IDENT:
            begin
                if (an || c == "_")
                begin
                    word_push(c);
                    advance();
                    return 1;
                end
                add_here(word_token_kind());
                sc_mode = M_IDLE;
                return 0;
            end
            M_STR:
            begin
                advance();
                if (c == "\"")
                begin
                    add_here(K_STRING);
                    sc_mode = M_IDLE;
                end
                else if (c == 8'h0A)
                    bump_line();
                return 1;
            end
            M_CMT:
            begin
                if (c == 8'h0A)
                begin
                    sc_mode = M_IDLE;
                    return 0;
                end
                advance();
                return 1;
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    sc_mode = M_CMT;
                    advance();
                    return 1;
                end
                add_here(K_SLASH);
                sc_mode = M_IDLE;
                return 0;
            end
            M_BANG: return pair(c, "=", K_BANG_EQ, K_BANG);
            M_EQ: return pair(c, "=", K_EQ_EQ, K_EQ);
            M_AMP: return pair(c, "&", K_AND_AND, K_AND);
            M_PIPE: return pair(c, "|", K_OR_OR, K_OR);
            M_GT:
            begin
                if (c == ">")
                begin
                    sc_mode = M_IDLE;
                    advance();
                    add_here(K_SHR);
                    return 1;
                end
                return pair(c, "=", K_GE, K_GT);
            end
            M_LT:
            begin
                if (c == "<")
                begin
                    sc_mode = M_IDLE;
                    advance();
                    add_here(K_SHL);
                    return 1;
                end
                return pair(c, "=", K_LE, K_LT);
            end
            default:
            begin
                sc_mode = M_IDLE;
                return 0;
            end
        endcase
    endfunction

    function automatic void scanner_reset();
        sc_mode = M_IDLE;
        sc_pos = '0;
        sc_begin = '0;
        sc_line = 24'd1;
        sc_word = '0;
        sc_chars = '0;
    endfunction

    function automatic void close_source();
        case (sc_mode)
            M_INT, M_FRAC, M_HEX: add_here(K_NUMBER);
            M_DOT: close_dot();
            M_XP:
            begin
                close_x();
                add_here(word_token_kind());
            end
            M_IDENT: add_here(word_token_kind());
            M_STR: add_here(K_ERR_UNTERM);
            M_SLASH: add_here(K_SLASH);
            M_BANG: add_here(K_BANG);
            M_EQ: add_here(K_EQ);
            M_GT: add_here(K_GT);
            M_LT: add_here(K_LT);
            M_AMP: add_here(K_AND);
            M_PIPE: add_here(K_OR);
            default: ;
        endcase
        put_token(K_END, sc_pos, 24'd0);
    endfunction

    function automatic void predict_tokens(request_t r);
        run_toks.delete();
        if (r.eos)
        begin
            close_source();
            scanner_reset();
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                if (scan_byte(r.ch))
                    break;
        end
        if (run_toks.size() > 0)
            run_toks[run_toks.size()-1].last = 1'b1;
        foreach (run_toks[i])
            expected_tokens.push_back(run_toks[i]);
    endfunction

    task automatic push_text(string s);
        request_t r;
        for (int i = 0; i < s.len(); i++)
        begin
            r.ch = s[i];
            r.eos = 1'b0;
            pending_reqs.push_back(r);
        end
    endtask

    task automatic push_byte(logic [7:0] c, logic eos);
        request_t r;
        r.ch = c;
        r.eos = eos;
        pending_reqs.push_back(r);
    endtask

    task automatic push_fragment();
        string frags[24];
        frags = '{"let ", "pointer", "uint64", "elseif", "print(", "12.5", "0x1F", "7X",
                  "3.", "9.x", "\"ab\ncd\"", "// note\n", ">>=", "<<", "<=", "&&",
                  "|||", "!=", "==", "counter_9", "foo_bar_baz", "\n", "\t ", "{;}"};
        if ($urandom_range(0, 9) < 7)
            push_text(frags[$urandom_range(0, 23)]);
        else
            push_byte(8'($urandom), 1'b0);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else if (!src_valid || src_taken)
        begin
            if (src_valid)
                void'(pending_reqs.pop_front());
            if (drain_pause && expected_tokens.size() != 0)
                src_valid <= 1'b0;
            else if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                src_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                if (!quiet_mode && $urandom_range(0, 19) == 0)
                begin
                    src_gap <= $urandom_range(1, 15);
                    src_valid <= 1'b0;
                end
                else
                begin
                    src_valid <= 1'b1;
                    source_byte <= pending_reqs[0].ch;
                    end_marker <= pending_reqs[0].eos;
                end
            end
            else
                src_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_long > 0)
        begin
            hold_long <= hold_long - 1;
            tok_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            tok_stall <= 1'b1;
        end
        else if (!quiet_mode && $urandom_range(0, 14) == 0)
        begin
            rx_gap <= $urandom_range(1, 15);
            tok_stall <= 1'b1;
        end
        else
            tok_stall <= 1'b0;
    end

    // request accept and token monitor
    always @(posedge clk)
    begin
        token_t e;
        src_taken <= src_valid && !src_stall;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (src_valid && !src_stall)
                predict_tokens('{source_byte, end_marker});
            if (tok_valid && !tok_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected token kind=%0d off=%0d", $time, token_kind,
                             token_offset);
                end
                else
                begin
                    e = expected_tokens.pop_front();
                    if (token_kind !== e.kind || token_offset !== e.offset ||
                        token_span !== e.span || token_line !== e.line ||
                        last_of_run !== e.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected k=%0d o=%0d s=%0d l=%0d last=%0d",
                                 $time, e.kind, e.offset, e.span, e.line, e.last);
                        $display("%0t:          actual   k=%0d o=%0d s=%0d l=%0d last=%0d",
                                 $time, token_kind, token_offset, token_span, token_line,
                                 last_of_run);
                    end
                end
            end
            if (cycles > LIMIT_CYCLES)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        src_valid = 1'b0;
        source_byte = '0;
        end_marker = 1'b0;
        tok_stall = 1'b0;
        errors = 0;
        cycles = 0;
        quiet_mode = 1'b0;
        hold_long = 0;
        drain_pause = 1'b0;
        src_gap = 0;
        rx_gap = 0;
        src_taken = 1'b0;
        scanner_reset();

        // directed: operators, numbers, keywords, specials, extremes of the byte
        push_text("(){},:;-+*%^~/!=<<>>&&||x 1.2 3.z 5x. 0xAf while ");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("\"open");
        push_byte(8'hA5, 1'b1);
        push_text("4x");
        push_byte(8'h00, 1'b1);
        push_text("int8 8.");
        push_byte(8'h00, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // long receiver hold while the sender keeps offering
        @(negedge clk);
        hold_long = 60;
        wait (pending_reqs.size() == 0);

        // sender pause until drained
        for (int i = 0; i < 8; i++)
            push_fragment();
        drain_pause = 1'b1;
        wait (expected_tokens.size() == 0 && pending_reqs.size() == 0);
        drain_pause = 1'b0;

        for (int i = 0; i < 14; i++)
        begin
            push_fragment();
            if ($urandom_range(0, 15) == 0)
                push_byte(8'($urandom), 1'b1);
        end
        wait (pending_reqs.size() < 20);
        quiet_mode = 1'b1;
        for (int i = 0; i < 8; i++)
            push_fragment();
        push_byte(8'h00, 1'b1);

        wait (pending_reqs.size() == 0 && expected_tokens.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/stt_pkg.sv
design/stt_scan.sv
design/stt_outq.sv
design/source_text_tokenizer.sv
design/stt_checker.sv
sim/source_text_tokenizer_tb.sv
